// ===== src/ipv4_address_text_scanner_top_defines.svh =====
// Assertion macros for the IPv4 address text scanner checker.
// Uses the checker's i_clk and i_rst_n; no other dependencies.
`ifndef IPV4_ADDRESS_TEXT_SCANNER_TOP_DEFINES_SVH
`define IPV4_ADDRESS_TEXT_SCANNER_TOP_DEFINES_SVH

// Clocked check, suspended while reset is asserted.
`define IP4S_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Clocked check that also covers the reset cycles.
`define IP4S_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// ===== src/ip4s_pkg.sv =====
// Shared types and constants for the IPv4 address text scanner.
// No dependencies.
`timescale 1ns / 1ps

package ip4s_pkg;

    localparam logic [7:0]  C_CH_ZERO      = 8'h30;
    localparam logic [7:0]  C_CH_NINE      = 8'h39;
    localparam logic [7:0]  C_CH_DOT       = 8'h2E;
    localparam logic [7:0]  C_CH_COLON     = 8'h3A;

    localparam logic [16:0] C_OCTET_MAX    = 17'd255;
    localparam logic [16:0] C_PORT_MAX     = 17'd65535;
    localparam logic [2:0]  C_OCTET_DIGITS = 3'd3;
    localparam logic [2:0]  C_PORT_DIGITS  = 3'd5;

    localparam logic [2:0]  C_GIDX_LAST    = 3'd3;
    localparam logic [2:0]  C_GIDX_PORT    = 3'd4;

    typedef struct packed {
        logic        found;
        logic [31:0] address;
        logic        has_port;
        logic [15:0] port;
    } t_result;

endpackage

// ===== src/ipv4_address_text_scanner_top.sv =====
// Scans a line of text for the first dotted-decimal IPv4 address with optional
// port, one character per item, and gives one result per line. The block takes
// one item every cycle: an input register feeds a single pass of compare and
// multiply-by-ten logic into the scan state, and a line's result is held in
// the result queue register before it reaches the output. A two-entry result
// queue lets input continue while a result waits; input stalls only when both
// entries are full. Depends on ip4s_pkg, ip4s_scan and ip4s_res_q.
`timescale 1ns / 1ps

module ipv4_address_text_scanner_top
    import ip4s_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_ch,
    input  logic        i_char_present,
    input  logic        i_end_of_line,
    output logic        o_valid,
    input  logic        i_ready,
    output logic        o_found,
    output logic [31:0] o_address,
    output logic        o_has_port,
    output logic [15:0] o_port
);

    logic       r_in_valid;
    logic [7:0] r_ch;
    logic       r_present;
    logic       r_eol;

    logic       q_full;
    logic       advance;
    logic       res_push;
    t_result    res;
    t_result    q_data;

    assign advance = r_in_valid && !q_full;
    assign o_ready = !r_in_valid || !q_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_ch      <= i_ch;
            r_present <= i_char_present;
            r_eol     <= i_end_of_line;
        end
    end

    ip4s_scan u_scan (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item_valid (advance),
        .i_ch         (r_ch),
        .i_present    (r_present),
        .i_eol        (r_eol),
        .o_res_push   (res_push),
        .o_res        (res)
    );

    ip4s_res_q u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_data  (res),
        .o_full  (q_full),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_data  (q_data)
    );

    assign o_found    = q_data.found;
    assign o_address  = q_data.address;
    assign o_has_port = q_data.has_port;
    assign o_port     = q_data.port;

endmodule

// ===== src/ip4s_scan.sv =====
// Per-character scan state and next-state logic for one line of text.
// Depends on ip4s_pkg.
`timescale 1ns / 1ps

module ip4s_scan
    import ip4s_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_item_valid,
    input  logic [7:0]  i_ch,
    input  logic        i_present,
    input  logic        i_eol,
    output logic        o_res_push,
    output t_result     o_res
);

    typedef struct packed {
        logic        in_run;
        logic [2:0]  gidx;
        logic [2:0]  dcnt;
        logic [16:0] gval;
        logic        lz;
        logic        rej;
        logic [31:0] acc;
        logic        matched;
        logic [31:0] m_addr;
        logic [15:0] m_port;
        logic        m_hp;
    } t_scan_st;

    t_scan_st r_st;
    t_scan_st n_st;
    t_result  n_res;

    function automatic logic is_digit(logic [7:0] c);
        return (c >= C_CH_ZERO) && (c <= C_CH_NINE);
    endfunction

    function automatic logic is_run_char(logic [7:0] c);
        return is_digit(c) || (c == C_CH_DOT) || (c == C_CH_COLON);
    endfunction

    function automatic logic octet_ok(t_scan_st st);
        return (st.dcnt != 3'd0) && (st.gval <= C_OCTET_MAX);
    endfunction

    function automatic t_scan_st run_char(t_scan_st st, logic [7:0] c);
        t_scan_st    r;
        logic [2:0]  lim;
        logic [7:0]  dig;
        r   = st;
        lim = (st.gidx >= C_GIDX_PORT) ? C_PORT_DIGITS : C_OCTET_DIGITS;
        dig = c - C_CH_ZERO;
        if (!st.rej) begin
            if (is_digit(c)) begin
                if ((st.dcnt >= lim) || ((st.dcnt != 3'd0) && st.lz)) begin
                    r.rej = 1'b1;
                end else begin
                    if ((st.dcnt == 3'd0) && (c == C_CH_ZERO)) begin
                        r.lz = 1'b1;
                    end
                    r.gval = (st.gval << 3) + (st.gval << 1) + {9'd0, dig};
                    r.dcnt = st.dcnt + 3'd1;
                end
            end else if (c == C_CH_DOT) begin
                if ((st.gidx < C_GIDX_LAST) && octet_ok(st)) begin
                    r.acc  = {st.acc[23:0], st.gval[7:0]};
                    r.gidx = st.gidx + 3'd1;
                    r.dcnt = 3'd0;
                    r.gval = '0;
                    r.lz   = 1'b0;
                end else begin
                    r.rej = 1'b1;
                end
            end else begin
                if ((st.gidx == C_GIDX_LAST) && octet_ok(st)) begin
                    r.acc  = {st.acc[23:0], st.gval[7:0]};
                    r.gidx = C_GIDX_PORT;
                    r.dcnt = 3'd0;
                    r.gval = '0;
                    r.lz   = 1'b0;
                end else begin
                    r.rej = 1'b1;
                end
            end
        end
        return r;
    endfunction

    function automatic t_scan_st close_run(t_scan_st st);
        t_scan_st r;
        r = st;
        if (st.in_run) begin
            r.in_run = 1'b0;
            if (!st.rej) begin
                if ((st.gidx == C_GIDX_LAST) && octet_ok(st)) begin
                    r.matched = 1'b1;
                    r.m_addr  = {st.acc[23:0], st.gval[7:0]};
                    r.m_hp    = 1'b0;
                    r.m_port  = '0;
                end else if ((st.gidx == C_GIDX_PORT) && (st.dcnt != 3'd0)
                             && (st.gval <= C_PORT_MAX)) begin
                    r.matched = 1'b1;
                    r.m_addr  = st.acc;
                    r.m_hp    = 1'b1;
                    r.m_port  = st.gval[15:0];
                end
            end
        end
        return r;
    endfunction

    always_comb begin
        t_scan_st s;
        s     = r_st;
        n_res = '0;
        if (i_item_valid) begin
            if (i_present && !s.matched) begin
                if (is_run_char(i_ch)) begin
                    if (!s.in_run) begin
                        s.in_run = 1'b1;
                        s.gidx   = 3'd0;
                        s.dcnt   = 3'd0;
                        s.gval   = '0;
                        s.lz     = 1'b0;
                        s.rej    = 1'b0;
                        s.acc    = '0;
                    end
                    s = run_char(s, i_ch);
                end else begin
                    s = close_run(s);
                end
            end
            if (i_eol) begin
                if (!s.matched) begin
                    s = close_run(s);
                end
                n_res.found    = s.matched;
                n_res.address  = s.m_addr;
                n_res.has_port = s.m_hp;
                n_res.port     = s.m_port;
                s              = '0;
            end
        end
        n_st = s;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= '0;
        end else begin
            r_st <= n_st;
        end
    end

    assign o_res_push = i_item_valid && i_eol;
    assign o_res      = n_res;

endmodule

// ===== src/ip4s_res_q.sv =====
// Two-entry result queue with registered data between scanner and output port.
// Depends on ip4s_pkg.
`timescale 1ns / 1ps

module ip4s_res_q
    import ip4s_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_result i_data,
    output logic    o_full,
    output logic    o_valid,
    input  logic    i_ready,
    output t_result o_data
);

    t_result    r_mem [2];
    logic       r_wr;
    logic       r_rd;
    logic [1:0] r_cnt;
    logic       pop;

    assign pop     = o_valid && i_ready;
    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_data  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr <= ~r_wr;
            end
            if (pop) begin
                r_rd <= ~r_rd;
            end
            case ({i_push, pop})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

// ===== src/ip4s_chk.sv =====
// Port-level checker for the IPv4 address text scanner, bound to the top level.
// Depends on ipv4_address_text_scanner_top_defines.svh.
`timescale 1ns / 1ps
`include "ipv4_address_text_scanner_top_defines.svh"

module ip4s_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_valid,
    input logic        i_ready,
    input logic        o_found,
    input logic [31:0] o_address,
    input logic        o_has_port,
    input logic [15:0] o_port
);

    `IP4S_ASSERT(a_out_hold, (o_valid && !i_ready) |=> o_valid, "result item dropped while stalled")
    `IP4S_ASSERT(a_miss_zero, (o_valid && !o_found) |-> (o_address == 32'd0 && !o_has_port), "no match but nonzero result")
    `IP4S_ASSERT(a_port_zero, (o_valid && !o_has_port) |-> (o_port == 16'd0), "port set without port flag")
    `IP4S_ASSERT(a_port_found, (o_valid && o_has_port) |-> o_found, "port flag without match")
    `IP4S_ASSERT_RST(a_rst_idle, !i_rst_n |=> !o_valid, "result valid right after reset")

endmodule

bind ipv4_address_text_scanner_top ip4s_chk u_ip4s_chk (.*);

// ===== sim/tb.sv =====
// Self-checking testbench for ipv4_address_text_scanner_top: walks a short directed table,
// then random lines of text, and checks every line result against the table or its own scanner model.
// Depends on ip4s_pkg and the scanner RTL.
`timescale 1ns / 1ps

module tb;
    import ip4s_pkg::*;

    localparam int     LIMIT_CYCLES = 200000;
    localparam int     PHASE_ITEMS  = 325;
    localparam int     HOLD_CYCLES  = 300;
    localparam t_result NONE_FOUND  = '0;

    typedef struct {
        logic [7:0] ch;
        logic       pres;
        logic       eol;
        bit         typed;
        t_result    res;
    } stim_t;

    logic        i_clk          = 1'b0;
    logic        i_rst_n        = 1'b0;
    logic        i_valid        = 1'b0;
    logic [7:0]  i_ch           = 8'h00;
    logic        i_char_present = 1'b0;
    logic        i_end_of_line  = 1'b0;
    logic        i_ready        = 1'b0;
    logic        o_ready;
    logic        o_valid;
    logic        o_found;
    logic [31:0] o_address;
    logic        o_has_port;
    logic [15:0] o_port;

    ipv4_address_text_scanner_top DUT (.*);

    always #2 i_clk = ~i_clk;

    // scanner model state
    logic        run_open;
    logic [2:0]  grp_idx;
    logic [2:0]  n_digits;
    logic [16:0] grp_val;
    logic        lead_zero;
    logic        run_bad;
    logic [31:0] addr_acc;
    logic        line_hit;
    logic [31:0] hit_addr;
    logic [15:0] hit_port;
    logic        hit_has_port;

    stim_t   stim_q[$];
    t_result pending_lines[$];

    int tx_pct_tab [4] = '{0, 49, 0, 31};
    int rx_pct_tab [4] = '{0, 0, 49, 31};
    int tx_idle    = 0;
    int rx_stall   = 0;
    bit hold_go    = 1'b0;
    logic rx_hold_on = 1'b0;
    int errors     = 0;
    int items_in   = 0;
    int lines_seen = 0;
    int addr_seen  = 0;
    int port_seen  = 0;
    int cycles     = 0;

    function automatic bit is_run_ch(input logic [7:0] c);
        return (c >= C_CH_ZERO && c <= C_CH_NINE) || c == C_CH_DOT || c == C_CH_COLON;
    endfunction

    function automatic bit octet_fits();
        return n_digits != 3'd0 && grp_val <= C_OCTET_MAX;
    endfunction

    function automatic void grp_clear();
        n_digits  = 3'd0;
        grp_val   = 17'd0;
        lead_zero = 1'b0;
    endfunction

    function automatic void scan_clear();
        run_open     = 1'b0;
        grp_idx      = 3'd0;
        grp_clear();
        run_bad      = 1'b0;
        addr_acc     = 32'd0;
        line_hit     = 1'b0;
        hit_addr     = 32'd0;
        hit_port     = 16'd0;
        hit_has_port = 1'b0;
    endfunction

    function automatic void scan_take(input logic [7:0] c);
        logic [2:0] lim;
        if (run_bad)
            return;
        if (c >= C_CH_ZERO && c <= C_CH_NINE) begin
            lim = (grp_idx >= C_GIDX_PORT) ? C_PORT_DIGITS : C_OCTET_DIGITS;
            if (n_digits >= lim || (n_digits != 3'd0 && lead_zero)) begin
                run_bad = 1'b1;
            end else begin
                if (n_digits == 3'd0 && c == C_CH_ZERO)
                    lead_zero = 1'b1;
                grp_val  = grp_val * 17'd10 + 17'(c - C_CH_ZERO);
                n_digits = n_digits + 3'd1;
            end
        end else if (c == C_CH_DOT) begin
            if (grp_idx < C_GIDX_LAST && octet_fits()) begin
                addr_acc = {addr_acc[23:0], grp_val[7:0]};
                grp_idx  = grp_idx + 3'd1;
                grp_clear();
            end else begin
                run_bad = 1'b1;
            end
        end else begin
            if (grp_idx == C_GIDX_LAST && octet_fits()) begin
                addr_acc = {addr_acc[23:0], grp_val[7:0]};
                grp_idx  = C_GIDX_PORT;
                grp_clear();
            end else begin
                run_bad = 1'b1;
            end
        end
    endfunction

    function automatic void scan_close();
        if (!run_open)
            return;
        run_open = 1'b0;
        if (run_bad)
            return;
        if (grp_idx == C_GIDX_LAST && octet_fits()) begin
            line_hit     = 1'b1;
            hit_addr     = {addr_acc[23:0], grp_val[7:0]};
            hit_has_port = 1'b0;
            hit_port     = 16'd0;
        end else if (grp_idx == C_GIDX_PORT && n_digits != 3'd0 && grp_val <= C_PORT_MAX) begin
            line_hit     = 1'b1;
            hit_addr     = addr_acc;
            hit_has_port = 1'b1;
            hit_port     = grp_val[15:0];
        end
    endfunction

    // returns 1 when the item ends a line; r is that line's result
    function automatic bit scan_item(input logic [7:0] c, input logic p, input logic e,
                                     output t_result r);
        r = '0;
        if (p && !line_hit) begin
            if (is_run_ch(c)) begin
                if (!run_open) begin
                    run_open = 1'b1;
                    grp_idx  = 3'd0;
                    grp_clear();
                    run_bad  = 1'b0;
                    addr_acc = 32'd0;
                end
                scan_take(c);
            end else begin
                scan_close();
            end
        end
        if (!e)
            return 1'b0;
        if (!line_hit)
            scan_close();
        if (line_hit) begin
            r.found    = 1'b1;
            r.address  = hit_addr;
            r.has_port = hit_has_port;
            r.port     = hit_has_port ? hit_port : 16'd0;
        end
        scan_clear();
        return 1'b1;
    endfunction

    function automatic void add_item(input logic [7:0] c, input logic p, input logic e,
                                     input bit typed, input t_result res);
        stim_q.push_back('{c, p, e, typed, res});
    endfunction

    function automatic void add_text(input string s, input bit gaps);
        for (int k = 0; k < s.len(); k++) begin
            if (gaps && $urandom_range(0, 19) == 0)
                add_item(8'($urandom_range(0, 255)), 1'b0, 1'b0, 1'b0, NONE_FOUND);
            add_item(s[k], 1'b1, 1'b0, 1'b0, NONE_FOUND);
        end
    endfunction

    function automatic void add_noise(input int n);
        logic [7:0] c;
        for (int k = 0; k < n; k++) begin
            do
                c = 8'($urandom_range(0, 255));
            while (is_run_ch(c));
            add_item(c, 1'b1, 1'b0, 1'b0, NONE_FOUND);
        end
    endfunction

    function automatic string octet_text();
        case ($urandom_range(0, 5))
            0:       return "0";
            1:       return "255";
            2:       return $sformatf("%0d", $urandom_range(1, 9));
            3:       return $sformatf("%0d", $urandom_range(250, 255));
            default: return $sformatf("%0d", $urandom_range(0, 255));
        endcase
    endfunction

    function automatic string port_text();
        case ($urandom_range(0, 5))
            0:       return "0";
            1:       return "65535";
            2:       return $sformatf("%0d", $urandom_range(1, 9));
            3:       return $sformatf("%0d", $urandom_range(65530, 65535));
            4:       return $sformatf("%0d", $urandom_range(10, 999));
            default: return $sformatf("%0d", $urandom_range(0, 65535));
        endcase
    endfunction

    function automatic string bad_group(input bit is_port);
        case ($urandom_range(0, 3))
            0: return "";
            1: return {"0", is_port ? port_text() : octet_text()};
            2: return is_port ? $sformatf("%0d", $urandom_range(65536, 99999))
                              : $sformatf("%0d", $urandom_range(256, 999));
            default: return is_port ? $sformatf("%0d", $urandom_range(100000, 999999))
                                    : $sformatf("%0d", $urandom_range(1000, 9999));
        endcase
    endfunction

    // mostly well-formed address runs; about a third carry one flaw
    function automatic string run_text();
        string r;
        string pick;
        int    flaw;
        int    sel;
        bit    with_port;
        pick      = "0123456789.:";
        r         = "";
        flaw      = ($urandom_range(0, 99) < 35) ? $urandom_range(1, 8) : 0;
        with_port = $urandom_range(0, 1) || flaw == 5;
        for (int g = 0; g < 4; g++) begin
            r = {r, (flaw == g + 1) ? bad_group(1'b0) : octet_text()};
            if (g < 3)
                r = {r, "."};
        end
        if (with_port)
            r = {r, ":", (flaw == 5) ? bad_group(1'b1) : port_text()};
        if (flaw == 6) begin
            r = r.substr(0, $urandom_range(0, r.len() - 2));
        end else if (flaw == 7) begin
            r = {r, ($urandom_range(0, 1) ? "." : ":"), octet_text()};
        end else if (flaw == 8) begin
            r = "";
            for (int k = $urandom_range(1, 12); k > 0; k--) begin
                sel = $urandom_range(0, 11);
                r   = {r, pick.substr(sel, sel)};
            end
        end
        return r;
    endfunction

    function automatic void add_line();
        int nrun;
        nrun = $urandom_range(0, 3);
        if (nrun == 3)
            nrun = 1;
        for (int k = 0; k < nrun; k++) begin
            if (k > 0 ? $urandom_range(0, 9) != 0 : $urandom_range(0, 2) == 0)
                add_noise($urandom_range(1, 3));
            add_text(run_text(), 1'b1);
        end
        if ($urandom_range(0, 2) == 0)
            add_noise($urandom_range(1, 3));
        if (stim_q.size() != 0 && $urandom_range(0, 3) == 0)
            stim_q[stim_q.size() - 1].eol = 1'b1;
        else
            add_item(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b1,
                     1'b0, NONE_FOUND);
    endfunction

    task automatic send_item(input stim_t s);
        t_result r;
        while ($urandom_range(0, 99) < tx_idle) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid        <= 1'b1;
        i_ch           <= s.ch;
        i_char_present <= s.pres;
        i_end_of_line  <= s.eol;
        @(posedge i_clk);
        while (!o_ready)
            @(posedge i_clk);
        if (scan_item(s.ch, s.pres, s.eol, r))
            pending_lines.push_back(s.typed ? s.res : r);
        if (s.pres || s.eol)
            items_in++;
    endtask

    task automatic check_field(input string what, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            $display("%0t %s: expected %0h, got %0h", $time, what, want, got);
            errors++;
        end
    endtask

    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_valid && i_ready) begin
            lines_seen++;
            if (o_found)
                addr_seen++;
            if (o_has_port)
                port_seen++;
            if (pending_lines.size() == 0) begin
                $display("%0t unexpected result: found %0b address %h has_port %0b port %h",
                         $time, o_found, o_address, o_has_port, o_port);
                errors++;
            end else begin
                want = pending_lines.pop_front();
                check_field("found", 32'(want.found), 32'(o_found));
                check_field("address", want.address, o_address);
                check_field("has_port", 32'(want.has_port), 32'(o_has_port));
                check_field("port", 32'(want.port), 32'(o_port));
            end
        end
        i_ready <= !rx_hold_on && ($urandom_range(0, 99) >= rx_stall);
    end

    // long receiver hold-off so the result queue fills and input backs up
    initial begin
        wait (hold_go);
        @(posedge i_clk);
        rx_hold_on <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        rx_hold_on <= 1'b0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT_CYCLES) begin
            $display("timeout after %0d cycles, %0d lines pending", cycles,
                     pending_lines.size());
            $display("ipv4_address_text_scanner_top test failed");
            $finish;
        end
    end

    initial begin
        int goal;
        scan_clear();

        // directed: empty line, match then ignored text, leading zero, bad separators
        add_item(8'h00, 1'b0, 1'b1, 1'b1, NONE_FOUND);
        add_text("9.9.9.9", 1'b0);
        add_item(8'hFF, 1'b1, 1'b0, 1'b0, NONE_FOUND);
        add_item(C_CH_ZERO + 8'd1, 1'b1, 1'b0, 1'b0, NONE_FOUND);
        add_item(8'hFF, 1'b0, 1'b1, 1'b1,
                 '{found: 1'b1, address: 32'h09090909, has_port: 1'b0, port: 16'h0});
        add_text("1.0.0.00", 1'b0);
        add_item(8'h00, 1'b1, 1'b1, 1'b1, NONE_FOUND);
        add_text("1..", 1'b0);
        add_item(C_CH_COLON, 1'b1, 1'b1, 1'b1, NONE_FOUND);

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (stim_q.size() != 0)
            send_item(stim_q.pop_front());

        for (int ph = 0; ph < 4; ph++) begin
            tx_idle  = tx_pct_tab[ph];
            rx_stall = rx_pct_tab[ph];
            if (ph == 0)
                hold_go = 1'b1;
            goal = items_in + PHASE_ITEMS;
            while (items_in < goal) begin
                add_line();
                while (stim_q.size() != 0)
                    send_item(stim_q.pop_front());
            end
        end

        i_valid  <= 1'b0;
        rx_stall = 0;
        while (pending_lines.size() != 0)
            @(posedge i_clk);
        repeat (10) @(posedge i_clk);

        $display("%0d characters and line ends in, %0d lines checked", items_in, lines_seen);
        $display("%0d lines held an address, %0d of them with a port", addr_seen, port_seen);
        if (errors == 0)
            $display("ipv4_address_text_scanner_top test passed");
        else
            $display("ipv4_address_text_scanner_top test failed");
        $finish;
    end

endmodule
